/* src/alignment_score_accumulator_core_macros.svh */
// Assertion macros used by the alignment score accumulator RTL.
`ifndef ALIGNMENT_SCORE_ACCUMULATOR_CORE_MACROS_SVH
`define ALIGNMENT_SCORE_ACCUMULATOR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/asa_pkg.sv */
// Package with shared types and constants of the alignment score accumulator.
`default_nettype none

package asa_pkg;

    // Number of symbols in the alphabet; the substitution table is always 4x4.
    localparam int ALPHABET_SIZE = 4;
    localparam int SYM_IDX_W     = 2;
    localparam int SYM_W         = 8;
    localparam int SCORE_W       = 32;
    localparam int ENTRY_W       = 8;
    localparam int GAP_W         = 16;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 64;

    // Column kind codes; the unused code counts as a match column.
    localparam logic [1:0] KIND_MATCH  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;

    // Gap run kind code meaning no run is recorded.
    localparam logic [1:0] RUN_NONE = 2'd0;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_GLOBAL_MODE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_WEIGHT      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHABET        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCORE_ROWS_LOW  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCORE_ROWS_HIGH = 3'd4;

    // One alignment column word.
    typedef struct packed {
        logic [1:0]       kind;
        logic [SYM_W-1:0] first_symbol;
        logic [SYM_W-1:0] second_symbol;
        logic             last_column;
    } asa_item_t;

    // Substitution lookup result for a match column.
    typedef struct packed {
        logic                      unknown;
        logic signed [ENTRY_W-1:0] entry;
    } asa_match_t;

endpackage

`default_nettype wire

/* src/asa_input_reg.sv */
// Input register stage holding one accepted alignment column word.
`default_nettype none

module asa_input_reg
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire asa_pkg::asa_item_t in_item,
    input  wire logic              take,
    output logic                   item_valid,
    output asa_pkg::asa_item_t     item
);
    import asa_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    asa_item_t item_reg;

    // The stage takes a new word when empty or when its word moves on.
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

/* src/asa_match_score.sv */
// Symbol lookup and substitution table read for a match column.
`default_nettype none

module asa_match_score
(
    input  wire logic [31:0]              alphabet_symbols,
    input  wire logic [63:0]              score_rows_low,
    input  wire logic [63:0]              score_rows_high,
    input  wire logic [asa_pkg::SYM_W-1:0] first_symbol,
    input  wire logic [asa_pkg::SYM_W-1:0] second_symbol,
    output asa_pkg::asa_match_t           result
);
    import asa_pkg::*;

    logic [SYM_IDX_W-1:0] first_idx;
    logic [SYM_IDX_W-1:0] second_idx;
    logic                 first_hit;
    logic                 second_hit;
    logic [127:0]         table_bits;

    // Lowest alphabet position with a matching code wins.
    always_comb
    begin
        first_idx  = '0;
        second_idx = '0;
        first_hit  = 1'b0;
        second_hit = 1'b0;
        for (int i = ALPHABET_SIZE - 1; i >= 0; i--)
        begin
            if (alphabet_symbols[SYM_W*i +: SYM_W] == first_symbol)
            begin
                first_idx = SYM_IDX_W'(i);
                first_hit = 1'b1;
            end
            if (alphabet_symbols[SYM_W*i +: SYM_W] == second_symbol)
            begin
                second_idx = SYM_IDX_W'(i);
                second_hit = 1'b1;
            end
        end
    end

    // Entry (r, c) is byte r*4+c of the two row registers taken together.
    assign table_bits     = {score_rows_high, score_rows_low};
    assign result.unknown = !(first_hit && second_hit);
    assign result.entry   = table_bits[{first_idx, second_idx, 3'b000} +: ENTRY_W];

endmodule

`default_nettype wire

/* src/asa_accum.sv */
// Score state, gap run tracking and result register.
`default_nettype none
`include "alignment_score_accumulator_core_macros.svh"

module asa_accum
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      global_mode,
    input  wire logic [asa_pkg::GAP_W-1:0] gap_weight,
    input  wire logic                      item_valid,
    input  wire asa_pkg::asa_item_t        item,
    input  wire asa_pkg::asa_match_t       match,
    output logic                           take,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [asa_pkg::SCORE_W-1:0] total_score,
    output logic                           unknown_symbol
);
    import asa_pkg::*;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    // Signed add clamped to the 32-bit range.
    function automatic logic signed [SCORE_W-1:0] sat_add(
        input logic signed [SCORE_W-1:0] x,
        input logic signed [SCORE_W-1:0] y
    );
        logic [SCORE_W:0] s;
        begin
            s = {x[SCORE_W-1], x} + {y[SCORE_W-1], y};
            if (s[SCORE_W] != s[SCORE_W-1])
            begin
                sat_add = s[SCORE_W] ? SCORE_MIN : SCORE_MAX;
            end
            else
            begin
                sat_add = s[SCORE_W-1:0];
            end
        end
    endfunction

    logic signed [SCORE_W-1:0] running_score_reg, running_score_next;
    logic signed [SCORE_W-1:0] pending_gap_sum_reg, pending_gap_sum_next;
    logic [1:0]                pending_gap_kind_reg, pending_gap_kind_next;
    logic                      in_leading_run_reg, in_leading_run_next;
    logic [1:0]                leading_run_kind_reg, leading_run_kind_next;
    logic                      symbol_error_reg, symbol_error_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [SCORE_W-1:0] total_score_reg;
    logic                      unknown_symbol_reg;

    logic signed [SCORE_W-1:0] gap_ext;
    logic signed [SCORE_W-1:0] entry_ext;
    logic signed [SCORE_W-1:0] committed;
    logic signed [SCORE_W-1:0] step_score;
    logic signed [SCORE_W-1:0] step_pending;
    logic [1:0]                step_pkind;
    logic                      step_lead;
    logic [1:0]                step_lkind;
    logic                      step_error;
    logic                      is_gap;
    logic                      lead_hit;
    logic                      kind_change;

    // A final column waits while the previous total is still unread.
    assign take = item_valid && !(item.last_column && out_valid_reg && !out_ready);

    assign gap_ext   = {{(SCORE_W-GAP_W){gap_weight[GAP_W-1]}}, gap_weight};
    assign entry_ext = {{(SCORE_W-ENTRY_W){match.entry[ENTRY_W-1]}}, match.entry};
    assign is_gap    = (item.kind == KIND_INSERT) || (item.kind == KIND_DELETE);
    assign committed = sat_add(running_score_reg, pending_gap_sum_reg);
    assign lead_hit  = in_leading_run_reg &&
                       (leading_run_kind_reg == RUN_NONE || leading_run_kind_reg == item.kind);
    assign kind_change = (pending_gap_kind_reg != item.kind);

    // Effect of one column on the score state.
    always_comb
    begin
        step_score   = running_score_reg;
        step_pending = pending_gap_sum_reg;
        step_pkind   = pending_gap_kind_reg;
        step_lead    = in_leading_run_reg;
        step_lkind   = leading_run_kind_reg;
        step_error   = symbol_error_reg || (!is_gap && match.unknown);
        if (global_mode || !is_gap)
        begin
            // Pending gaps are committed, then the column adds its own cost (none for an unknown symbol).
            step_lead    = 1'b0;
            step_pending = '0;
            step_pkind   = RUN_NONE;
            if (is_gap)
            begin
                step_score = sat_add(committed, gap_ext);
            end
            else if (match.unknown)
            begin
                step_score = committed;
            end
            else
            begin
                step_score = sat_add(committed, entry_ext);
            end
        end
        else if (lead_hit)
        begin
            // Leading run in local mode costs nothing.
            step_lkind = item.kind;
        end
        else
        begin
            // Gaps after the leading run stay pending until a later column counts them.
            step_lead  = 1'b0;
            step_pkind = item.kind;
            if (kind_change)
            begin
                step_score   = committed;
                step_pending = sat_add('0, gap_ext);
            end
            else
            begin
                step_pending = sat_add(pending_gap_sum_reg, gap_ext);
            end
        end
    end

    // When a column is taken, the final column clears the state; any other column sets the step result.
    always_comb
    begin
        running_score_next    = running_score_reg;
        pending_gap_sum_next  = pending_gap_sum_reg;
        pending_gap_kind_next = pending_gap_kind_reg;
        in_leading_run_next   = in_leading_run_reg;
        leading_run_kind_next = leading_run_kind_reg;
        symbol_error_next     = symbol_error_reg;
        if (take)
        begin
            if (item.last_column)
            begin
                running_score_next    = '0;
                pending_gap_sum_next  = '0;
                pending_gap_kind_next = RUN_NONE;
                in_leading_run_next   = 1'b1;
                leading_run_kind_next = RUN_NONE;
                symbol_error_next     = 1'b0;
            end
            else
            begin
                running_score_next    = step_score;
                pending_gap_sum_next  = step_pending;
                pending_gap_kind_next = step_pkind;
                in_leading_run_next   = step_lead;
                leading_run_kind_next = step_lkind;
                symbol_error_next     = step_error;
            end
        end
    end

    assign out_valid_next = (take && item.last_column) ? 1'b1 :
                            (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_score_reg    <= '0;
            pending_gap_sum_reg  <= '0;
            pending_gap_kind_reg <= RUN_NONE;
            in_leading_run_reg   <= 1'b1;
            leading_run_kind_reg <= RUN_NONE;
            symbol_error_reg     <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            running_score_reg    <= running_score_next;
            pending_gap_sum_reg  <= pending_gap_sum_next;
            pending_gap_kind_reg <= pending_gap_kind_next;
            in_leading_run_reg   <= in_leading_run_next;
            leading_run_kind_reg <= leading_run_kind_next;
            symbol_error_reg     <= symbol_error_next;
            out_valid_reg        <= out_valid_next;
        end
    end

    // Result word; a pending trailing run is simply left out of the total.
    always_ff @(posedge clk)
    begin
        if (take && item.last_column)
        begin
            total_score_reg    <= step_score;
            unknown_symbol_reg <= step_error;
        end
    end

    assign out_valid      = out_valid_reg;
    assign total_score    = total_score_reg;
    assign unknown_symbol = unknown_symbol_reg;

    `ASA_ASSERT_NEXT(a_clear_after_last, take && item.last_column, running_score_reg == '0 && pending_gap_sum_reg == '0 && in_leading_run_reg && !symbol_error_reg && out_valid_reg, "state not cleared after final column")
    `ASA_ASSERT_SAME(a_pending_has_kind, pending_gap_sum_reg != '0, pending_gap_kind_reg != RUN_NONE, "pending gap sum without a run kind")
    `ASA_ASSERT_NEXT(a_global_no_pending, take && global_mode, pending_gap_sum_reg == '0 && pending_gap_kind_reg == RUN_NONE, "pending gaps left in global mode")

endmodule

`default_nettype wire

/* src/alignment_score_accumulator_core.sv */
// A column word passes the input register and then, if final, the result register; a stall can hold it in between.
// Throughput: one column word per cycle unless a final column stalls; the input register and result register
// let a new word enter while an unread total waits.
// A final column stalls only while the previous total is still unread.
// Reset (rst_n low, asynchronous) clears the score state and restores the register defaults.
// Top level of the alignment score accumulator.
`default_nettype none

module alignment_score_accumulator_core
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      kind,
    input  wire logic [asa_pkg::SYM_W-1:0]       first_symbol,
    input  wire logic [asa_pkg::SYM_W-1:0]       second_symbol,
    input  wire logic                            last_column,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [asa_pkg::SCORE_W-1:0]   total_score,
    output logic                                 unknown_symbol,
    input  wire logic                            cfg_we,
    input  wire logic [asa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [asa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import asa_pkg::*;

    logic             global_mode_reg;
    logic [GAP_W-1:0] gap_weight_reg;
    logic [31:0]      alphabet_symbols_reg;
    logic [63:0]      score_rows_low_reg;
    logic [63:0]      score_rows_high_reg;

    asa_item_t  in_item;
    asa_item_t  item;
    asa_match_t match;
    logic       item_valid;
    logic       take;

    // Configuration registers, written one at a time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            global_mode_reg      <= 1'b1;
            gap_weight_reg       <= {GAP_W{1'b1}};
            alphabet_symbols_reg <= 32'h5443_4741;
            score_rows_low_reg   <= '0;
            score_rows_high_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GLOBAL_MODE:     global_mode_reg      <= cfg_data[0];
                CFG_GAP_WEIGHT:      gap_weight_reg       <= cfg_data[GAP_W-1:0];
                CFG_ALPHABET:        alphabet_symbols_reg <= cfg_data[31:0];
                CFG_SCORE_ROWS_LOW:  score_rows_low_reg   <= cfg_data;
                CFG_SCORE_ROWS_HIGH: score_rows_high_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign in_item.kind          = kind;
    assign in_item.first_symbol  = first_symbol;
    assign in_item.second_symbol = second_symbol;
    assign in_item.last_column   = last_column;

    asa_input_reg u_input_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    asa_match_score u_match_score
    (
        .alphabet_symbols (alphabet_symbols_reg),
        .score_rows_low   (score_rows_low_reg),
        .score_rows_high  (score_rows_high_reg),
        .first_symbol     (item.first_symbol),
        .second_symbol    (item.second_symbol),
        .result           (match)
    );

    asa_accum u_accum
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .global_mode    (global_mode_reg),
        .gap_weight     (gap_weight_reg),
        .item_valid     (item_valid),
        .item           (item),
        .match          (match),
        .take           (take),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .total_score    (total_score),
        .unknown_symbol (unknown_symbol)
    );

endmodule

`default_nettype wire
